@@ src/bucketized_cuckoo_hash_table_defines.svh @@
// Assertion macros for the RTL
`ifndef BUCKETIZED_CUCKOO_HASH_TABLE_DEFINES_SVH
`define BUCKETIZED_CUCKOO_HASH_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BCHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcht assertion failed");
`define BCHT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bcht forbidden condition");
`else
`define BCHT_ASSERT(lbl, clk, rst_n, prop)
`define BCHT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ src/bcht_pkg.sv @@
`default_nettype none
package bcht_pkg;
    localparam int BUCKETS          = 1024;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int KEY_BITS         = 64;
    localparam int PAYLOAD_BITS     = 64;
    localparam int HASH_BITS        = 32;
    localparam int NSLOTS           = BUCKETS * SLOTS_PER_BUCKET;
    localparam int IDX_BITS         = $clog2(NSLOTS);
    localparam int BKT_BITS         = $clog2(BUCKETS);
    localparam int SLOT_BITS        = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int LOG_DEPTH        = 128;
    localparam int LOG_BITS         = 7;
    localparam int LIMIT_BITS       = 7;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd40;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RS_OK   = 2'd0,
        RS_MISS = 2'd1,
        RS_FULL = 2'd2
    } t_rsp_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD,
        S_EVAL,
        S_EVICT,
        S_UNDO_RD,
        S_UNDO_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [HASH_BITS-1:0]    tag;
        logic [HASH_BITS-1:0]    alt;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_slot;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        t_slot               slot;
    } t_log;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_slot;
        logic eval;
        logic wr_fill;
        logic wr_update;
        logic wr_del;
        logic set_found;
        logic next_slot;
        logic next_bucket;
        logic evict;
        logic undo_rd;
        logic undo_wr;
        logic set_full;
        logic set_miss;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        t_op  op;
        logic empty;
        logic match;
        logic last_slot;
        logic second;
        logic at_limit;
        logic log_zero;
    } t_dp_sts;
endpackage
`default_nettype wire

@@ src/bcht_intf.sv @@
`default_nettype none
interface bcht_req_if;
    import bcht_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [KEY_BITS-1:0]  key;
    logic [63:0]          value;
    logic [HASH_BITS-1:0] first_hash;
    logic [HASH_BITS-1:0] second_hash;
    modport source (output valid, cmd, key, value, first_hash, second_hash, input ready);
    modport sink   (input valid, cmd, key, value, first_hash, second_hash, output ready);
endinterface

interface bcht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

@@ src/bucketized_cuckoo_hash_table.sv @@
// Lookup and delete read and evaluate slot by slot, over up to two buckets of 4 slots.
// Insert scans one bucket, then evicts a victim; when the limit is reached every move is undone.
// One item at a time; throughput is set by the registered slot RAM read.
// Reset (synchronous, active low) runs a clearing pass over all 4096 slots of the slot RAM,
// during which no item is accepted; the displacement limit (r_limit) resets to 40.
`default_nettype none
`include "bucketized_cuckoo_hash_table_defines.svh"
module bucketized_cuckoo_hash_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bcht_pkg::LIMIT_BITS-1:0] i_cfg_data,
    bcht_req_if.sink                             i_req,
    bcht_rsp_if.source                           o_rsp
);
    import bcht_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    bcht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bcht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_op      (i_req.cmd),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .i_first_hash  (i_req.first_hash),
        .i_second_hash (i_req.second_hash),
        .o_status      (o_rsp.status),
        .o_found_value (o_rsp.found_value),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    `BCHT_ASSERT(a_one_slot_write, i_clk, i_rst_n, $onehot0({cmd.clr_wr, cmd.wr_fill, cmd.wr_update, cmd.wr_del, cmd.evict, cmd.undo_wr}))
    `BCHT_ASSERT(a_busy_after_transfer, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready)
    `BCHT_NEVER(a_undo_only_insert, i_clk, i_rst_n, (cmd.undo_wr || cmd.evict) && sts.op != OP_INSERT)
endmodule
`default_nettype wire

@@ src/bcht_ram.sv @@
`default_nettype none
module bcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ src/bcht_ctrl.sv @@
`default_nettype none
module bcht_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bcht_pkg::t_dp_cmd      o_cmd,
    input  wire bcht_pkg::t_dp_sts i_sts
);
    import bcht_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.at_limit) begin
                            o_cmd.set_full = 1'b1;
                            n_state = i_sts.log_zero ? S_RESP : S_UNDO_RD;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    OP_DELETE, OP_LOOKUP: n_state = S_RD;
                    default: n_state = S_RESP;
                endcase
            end
            S_RD: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.op == OP_INSERT) begin
                    if (i_sts.empty) begin
                        o_cmd.wr_fill = 1'b1;
                        n_state       = S_RESP;
                    end else if (i_sts.match) begin
                        o_cmd.wr_update = 1'b1;
                        n_state         = S_RESP;
                    end else if (i_sts.last_slot) begin
                        n_state = S_EVICT;
                    end else begin
                        o_cmd.next_slot = 1'b1;
                        n_state         = S_RD;
                    end
                end else if (i_sts.match) begin
                    if (i_sts.op == OP_DELETE) begin
                        o_cmd.wr_del = 1'b1;
                    end else begin
                        o_cmd.set_found = 1'b1;
                    end
                    n_state = S_RESP;
                end else if (i_sts.last_slot) begin
                    if (i_sts.second) begin
                        o_cmd.set_miss = (i_sts.op == OP_LOOKUP);
                        n_state        = S_RESP;
                    end else begin
                        o_cmd.next_bucket = 1'b1;
                        n_state           = S_RD;
                    end
                end else begin
                    o_cmd.next_slot = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_START;
            end
            S_UNDO_RD: begin
                o_cmd.undo_rd = 1'b1;
                n_state       = S_UNDO_WR;
            end
            S_UNDO_WR: begin
                o_cmd.undo_wr = 1'b1;
                n_state = i_sts.log_zero ? S_RESP : S_UNDO_RD;
            end
            S_RESP: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

@@ src/bcht_dp.sv @@
`default_nettype none
module bcht_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bcht_pkg::LIMIT_BITS-1:0] i_cfg_data,
    input  wire logic [1:0]                      i_cmd_op,
    input  wire logic [bcht_pkg::KEY_BITS-1:0]   i_key,
    input  wire logic [63:0]                     i_value,
    input  wire logic [bcht_pkg::HASH_BITS-1:0]  i_first_hash,
    input  wire logic [bcht_pkg::HASH_BITS-1:0]  i_second_hash,
    output logic      [1:0]                      o_status,
    output logic      [63:0]                     o_found_value,
    input  wire bcht_pkg::t_dp_cmd               i_cmd,
    output bcht_pkg::t_dp_sts                    o_sts
);
    import bcht_pkg::*;

    t_op                     r_op;
    logic [HASH_BITS-1:0]    r_c1, r_c2;
    logic [KEY_BITS-1:0]     r_ck;
    logic [PAYLOAD_BITS-1:0] r_cp;
    logic [SLOT_BITS-1:0]    r_e, r_off;
    logic [LOG_BITS-1:0]     r_n;
    logic                    r_second;
    t_slot                   r_vic;
    t_rsp_status             r_status;
    logic [PAYLOAD_BITS-1:0] r_found;
    logic [IDX_BITS-1:0]     r_clr;
    logic [LIMIT_BITS-1:0]   r_limit;
    logic [1:0]              r_out_status;
    logic [63:0]             r_out_found;

    logic                sl_we;
    logic [IDX_BITS-1:0] sl_waddr, cur_idx, off_idx;
    t_slot               sl_wdata, sl_rdata, carrier;
    t_log                lg_wdata, lg_rdata;
    logic [HASH_BITS-1:0] h2_eff;

    assign cur_idx = IDX_BITS'(r_c1[BKT_BITS-1:0]) * IDX_BITS'(SLOTS_PER_BUCKET)
                   + IDX_BITS'(r_e);
    assign off_idx = IDX_BITS'(r_c1[BKT_BITS-1:0]) * IDX_BITS'(SLOTS_PER_BUCKET)
                   + IDX_BITS'(r_off);
    assign carrier = '{tag: r_c1, alt: r_c2, key: r_ck, pay: r_cp};
    assign h2_eff  = (i_first_hash == i_second_hash) ? ~i_first_hash : i_second_hash;

    always_comb begin
        sl_we    = 1'b1;
        sl_waddr = cur_idx;
        sl_wdata = '0;
        if (i_cmd.clr_wr) begin
            sl_waddr = r_clr;
        end else if (i_cmd.wr_fill) begin
            sl_wdata = carrier;
        end else if (i_cmd.wr_update) begin
            sl_wdata     = sl_rdata;
            sl_wdata.pay = r_cp;
        end else if (i_cmd.evict) begin
            sl_waddr = off_idx;
            sl_wdata = carrier;
        end else if (i_cmd.undo_wr) begin
            sl_waddr = lg_rdata.idx;
            sl_wdata = lg_rdata.slot;
        end else if (!i_cmd.wr_del) begin
            sl_we = 1'b0;
        end
    end

    assign lg_wdata = '{idx: off_idx, slot: r_vic};

    bcht_ram #(.WIDTH($bits(t_slot)), .DEPTH(NSLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata (sl_wdata),
        .i_re    (i_cmd.rd_slot),
        .i_raddr (cur_idx),
        .o_rdata (sl_rdata)
    );

    bcht_ram #(.WIDTH($bits(t_log)), .DEPTH(LOG_DEPTH)) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.evict),
        .i_waddr (r_n),
        .i_wdata (lg_wdata),
        .i_re    (i_cmd.undo_rd),
        .i_raddr (r_n - LOG_BITS'(1)),
        .o_rdata (lg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + IDX_BITS'(1);
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_cmd_op);
            r_c1     <= i_first_hash;
            r_c2     <= h2_eff;
            r_ck     <= i_key;
            r_cp     <= PAYLOAD_BITS'(i_value);
            r_e      <= '0;
            r_off    <= '0;
            r_n      <= '0;
            r_second <= 1'b0;
            r_status <= RS_OK;
            r_found  <= '0;
        end
        if (i_cmd.eval && r_e == r_off) begin
            r_vic <= sl_rdata;
        end
        if (i_cmd.next_slot) begin
            r_e <= r_e + SLOT_BITS'(1);
        end
        if (i_cmd.next_bucket) begin
            r_c1     <= r_c2;
            r_e      <= '0;
            r_second <= 1'b1;
        end
        if (i_cmd.evict) begin
            // carry the victim on to its alternate bucket
            r_c1  <= r_vic.alt;
            r_c2  <= r_vic.tag;
            r_ck  <= r_vic.key;
            r_cp  <= r_vic.pay;
            r_e   <= '0;
            r_n   <= r_n + LOG_BITS'(1);
            r_off <= (r_off == SLOT_BITS'(SLOTS_PER_BUCKET - 1)) ? '0
                                                                 : r_off + SLOT_BITS'(1);
        end
        if (i_cmd.undo_rd) begin
            r_n <= r_n - LOG_BITS'(1);
        end
        if (i_cmd.set_found) begin
            r_found <= sl_rdata.pay;
        end
        if (i_cmd.set_full) begin
            r_status <= RS_FULL;
        end
        if (i_cmd.set_miss) begin
            r_status <= RS_MISS;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_found  <= 64'(r_found);
        end
    end

    assign o_sts.clr_last  = (r_clr == IDX_BITS'(NSLOTS - 1));
    assign o_sts.op        = r_op;
    assign o_sts.empty     = (sl_rdata.tag == '0);
    assign o_sts.match     = (sl_rdata.tag != '0) && (sl_rdata.tag == r_c1)
                          && (sl_rdata.key == r_ck);
    assign o_sts.last_slot = (r_e == SLOT_BITS'(SLOTS_PER_BUCKET - 1));
    assign o_sts.second    = r_second;
    assign o_sts.at_limit  = (r_n == r_limit);
    assign o_sts.log_zero  = (r_n == '0);

    assign o_status      = r_out_status;
    assign o_found_value = r_out_found;
endmodule
`default_nettype wire

@@ tb/tb_bucketized_cuckoo_hash_table.sv @@
`default_nettype none
module tb_bucketized_cuckoo_hash_table;
    timeunit 1ns;
    timeprecision 1ps;
    import bcht_pkg::*;

    typedef enum logic [1:0] {
        K_OP,
        K_CFG,
        K_HOLD
    } t_kind;

    typedef struct {
        t_kind                   kind;
        t_op                     op;
        logic [KEY_BITS-1:0]     key;
        logic [63:0]             value;
        logic [HASH_BITS-1:0]    h1;
        logic [HASH_BITS-1:0]    h2;
        logic [LIMIT_BITS-1:0]   limit;
    } t_item;

    typedef struct {
        t_rsp_status status;
        logic [63:0] found;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [LIMIT_BITS-1:0] i_cfg_data = '0;

    bcht_req_if req_if ();
    bcht_rsp_if rsp_if ();

    bucketized_cuckoo_hash_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the slot RAM
    logic [HASH_BITS-1:0]    tbl_tag [NSLOTS];
    logic [HASH_BITS-1:0]    tbl_alt [NSLOTS];
    logic [KEY_BITS-1:0]     tbl_key [NSLOTS];
    logic [PAYLOAD_BITS-1:0] tbl_pay [NSLOTS];
    logic [LIMIT_BITS-1:0]   kick_limit = LIMIT_RESET;

    t_item   pending [$];
    t_answer answers [$];
    int      mismatches = 0;
    int      accepted = 0;
    int      quiet = 0;

    function automatic void write_slot(int i, logic [HASH_BITS-1:0] tag,
                                       logic [HASH_BITS-1:0] alt,
                                       logic [KEY_BITS-1:0] k, logic [PAYLOAD_BITS-1:0] p);
        tbl_tag[i] = tag;
        tbl_alt[i] = alt;
        tbl_key[i] = k;
        tbl_pay[i] = p;
    endfunction

    function automatic int bucket_base(logic [HASH_BITS-1:0] h);
        return int'(h[BKT_BITS-1:0]) * SLOTS_PER_BUCKET;
    endfunction

    function automatic int probe(logic [KEY_BITS-1:0] k, logic [HASH_BITS-1:0] h);
        int base;
        base = bucket_base(h);
        for (int e = 0; e < SLOTS_PER_BUCKET; e++) begin
            if (tbl_tag[base+e] != 0 && tbl_tag[base+e] == h && tbl_key[base+e] == k)
                return base + e;
        end
        return -1;
    endfunction

    function automatic t_rsp_status cuckoo_insert(logic [KEY_BITS-1:0] k,
                                                  logic [PAYLOAD_BITS-1:0] p,
                                                  logic [HASH_BITS-1:0] h1,
                                                  logic [HASH_BITS-1:0] h2);
        logic [HASH_BITS-1:0]    c1, c2, o_tag, o_alt;
        logic [KEY_BITS-1:0]     ck, o_key;
        logic [PAYLOAD_BITS-1:0] cp, o_pay;
        int log_idx [LOG_DEPTH];
        logic [HASH_BITS-1:0]    log_tag [LOG_DEPTH];
        logic [HASH_BITS-1:0]    log_alt [LOG_DEPTH];
        logic [KEY_BITS-1:0]     log_key [LOG_DEPTH];
        logic [PAYLOAD_BITS-1:0] log_pay [LOG_DEPTH];
        int off, n, base, i;
        c1 = h1; c2 = h2; ck = k; cp = p;
        off = 0; n = 0;
        for (int d = 0; d < int'(kick_limit); d++) begin
            base = bucket_base(c1);
            for (int e = 0; e < SLOTS_PER_BUCKET; e++) begin
                i = base + e;
                if (tbl_tag[i] == 0) begin
                    write_slot(i, c1, c2, ck, cp);
                    return RS_OK;
                end
                if (tbl_tag[i] == c1 && tbl_key[i] == ck) begin
                    tbl_pay[i] = cp;
                    return RS_OK;
                end
            end
            i = base + off;
            o_tag = tbl_tag[i]; o_alt = tbl_alt[i]; o_key = tbl_key[i]; o_pay = tbl_pay[i];
            log_idx[n] = i; log_tag[n] = o_tag; log_alt[n] = o_alt;
            log_key[n] = o_key; log_pay[n] = o_pay;
            write_slot(i, c1, c2, ck, cp);
            // carry the victim on to its other bucket
            c1 = o_alt; c2 = o_tag; ck = o_key; cp = o_pay;
            n++;
            off = (off + 1) % SLOTS_PER_BUCKET;
        end
        while (n > 0) begin
            n--;
            write_slot(log_idx[n], log_tag[n], log_alt[n], log_key[n], log_pay[n]);
        end
        return RS_FULL;
    endfunction

    function automatic t_answer table_answer(t_item it);
        t_answer a;
        logic [HASH_BITS-1:0] h2;
        int w;
        a.status = RS_OK;
        a.found = '0;
        h2 = (it.h1 == it.h2) ? ~it.h1 : it.h2;
        case (it.op)
            OP_INSERT: a.status = cuckoo_insert(it.key, it.value, it.h1, h2);
            OP_DELETE: begin
                w = probe(it.key, it.h1);
                if (w < 0) w = probe(it.key, h2);
                if (w >= 0) write_slot(w, '0, '0, '0, '0);
            end
            OP_LOOKUP: begin
                w = probe(it.key, it.h1);
                if (w < 0) w = probe(it.key, h2);
                if (w >= 0) a.found = tbl_pay[w];
                else a.status = RS_MISS;
            end
            default: ;
        endcase
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                answers.push_back(table_answer(pending.pop_front()));
                accepted++;
            end
            quiet = (answers.size() == 0 && !(req_if.valid && !req_if.ready)) ? quiet + 1 : 0;
            if ((!req_if.valid || req_if.ready) && pending.size() > 0 &&
                pending[0].kind != K_OP) begin
                // hold off until every result is back, then apply the control item
                req_if.valid <= 1'b0;
                if (quiet >= 12 && pending[0].kind == K_CFG) begin
                    i_cfg_we <= 1'b1;
                    i_cfg_data <= pending[0].limit;
                    kick_limit = pending[0].limit;
                end else begin
                    i_cfg_we <= 1'b0;
                end
                if (quiet >= 12) begin
                    void'(pending.pop_front());
                    quiet = 0;
                end
            end else begin
                i_cfg_we <= 1'b0;
                if (!req_if.valid || req_if.ready) begin
                    if (pending.size() > 0 &&
                        ((accepted > 300 && accepted < 450) || $urandom_range(99) >= 22)) begin
                        req_if.valid <= 1'b1;
                        req_if.cmd <= pending[0].op;
                        req_if.key <= pending[0].key;
                        req_if.value <= pending[0].value;
                        req_if.first_hash <= pending[0].h1;
                        req_if.second_hash <= pending[0].h2;
                    end else begin
                        req_if.valid <= 1'b0;
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: status %0d value %h",
                                 rsp_if.status, rsp_if.found_value);
                end else begin
                    want = answers.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.found_value !== want.found) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                                     want.status, rsp_if.status, want.found,
                                     rsp_if.found_value);
                    end
                end
            end
            rsp_if.ready <= (accepted > 300 && accepted < 450) || $urandom_range(99) >= 22;
        end
    end

    logic [KEY_BITS-1:0]  pool_key [48];
    logic [HASH_BITS-1:0] pool_h1 [48];
    logic [HASH_BITS-1:0] pool_h2 [48];

    function automatic logic [HASH_BITS-1:0] near_hash(int buckets);
        logic [HASH_BITS-1:0] h;
        h = $urandom();
        h[BKT_BITS-1:0] = BKT_BITS'($urandom_range(buckets - 1));
        return h;
    endfunction

    function automatic t_item make_op(t_op op, logic [KEY_BITS-1:0] k, logic [63:0] v,
                                      logic [HASH_BITS-1:0] h1, logic [HASH_BITS-1:0] h2);
        t_item it;
        it.kind = K_OP; it.op = op; it.key = k; it.value = v;
        it.h1 = h1; it.h2 = h2; it.limit = '0;
        return it;
    endfunction

    function automatic t_item make_ctl(t_kind kind, logic [LIMIT_BITS-1:0] lim);
        t_item it;
        it = make_op(OP_NOP, '0, '0, '0, '0);
        it.kind = kind;
        it.limit = lim;
        return it;
    endfunction

    function automatic void add_random(int count);
        int p, r;
        t_op op;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(47);
            r = $urandom_range(99);
            op = (r < 50) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 97) ? OP_LOOKUP : OP_NOP;
            if ($urandom_range(9) < 8)
                pending.push_back(make_op(op, pool_key[p], {$urandom(), $urandom()},
                                          pool_h1[p], pool_h2[p]));
            else
                pending.push_back(make_op(t_op'($urandom_range(3)),
                                          {$urandom(), $urandom()}, {$urandom(), $urandom()},
                                          $urandom(), $urandom()));
        end
    endfunction

    initial begin
        for (int i = 0; i < 48; i++) begin
            pool_key[i] = {$urandom(), $urandom()};
            pool_h1[i] = near_hash(6);
            pool_h2[i] = near_hash(6);
        end
        for (int i = 0; i < NSLOTS; i++) write_slot(i, '0, '0, '0, '0);

        pending.push_back(make_ctl(K_CFG, 7'd1));
        // five keys all hashing to bucket 9: the fifth overflows and bounces back full
        for (int i = 0; i < 5; i++)
            pending.push_back(make_op(OP_INSERT, 64'(i + 1), 64'(100 + i),
                                      32'h0000_0409 + 32'(i << 12), 32'h0000_0009 + 32'(i << 16)));
        pending.push_back(make_op(OP_LOOKUP, 64'd5, '0, 32'h0000_4409, 32'h0004_0009));
        pending.push_back(make_op(OP_LOOKUP, 64'd2, '0, 32'h0000_1409, 32'h0001_0009));
        pending.push_back(make_op(OP_INSERT, '0, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(make_op(OP_LOOKUP, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(make_op(OP_LOOKUP, '0, '0, 32'h0000_0000, 32'h0000_0000));
        pending.push_back(make_op(OP_INSERT, '1, 64'h55AA, 32'h0000_0000, 32'h1234_5678));
        pending.push_back(make_op(OP_LOOKUP, '1, '0, 32'h0000_0000, 32'h1234_5678));
        pending.push_back(make_op(OP_INSERT, '1, 64'h77, 32'h0000_0000, 32'h1234_5678));
        pending.push_back(make_op(OP_INSERT, 64'd3, 64'hDEAD, 32'h0000_1409, 32'h0001_0009));
        pending.push_back(make_op(OP_LOOKUP, 64'd3, '0, 32'h0000_0009, 32'h0000_1409));
        pending.push_back(make_op(OP_DELETE, 64'd3, '0, 32'h0000_1409, 32'h0001_0009));
        pending.push_back(make_op(OP_DELETE, 64'd3, '0, 32'h0000_1409, 32'h0001_0009));
        pending.push_back(make_op(OP_LOOKUP, 64'd3, '0, 32'h0000_1409, 32'h0001_0009));
        pending.push_back(make_op(OP_NOP, '1, '1, '1, '0));
        pending.push_back(make_op(OP_INSERT, 64'd3, 64'hBEEF, 32'h0000_1409, 32'h0001_0009));
        pending.push_back(make_op(OP_LOOKUP, 64'd3, '0, 32'h0001_0009, 32'h0000_1409));

        pending.push_back(make_ctl(K_CFG, 7'd64));
        add_random(300);
        pending.push_back(make_ctl(K_HOLD, '0));
        add_random(100);
        pending.push_back(make_ctl(K_CFG, 7'd2));
        add_random(180);
        pending.push_back(make_ctl(K_CFG, LIMIT_RESET));
        add_random(160);
        pending.push_back(make_ctl(K_CFG, LIMIT_BITS'($urandom_range(64, 1))));
        add_random(160);

        do @(posedge i_clk); while (pending.size() != 0 || req_if.valid || answers.size() != 0);
        repeat (40) @(posedge i_clk);
        if (answers.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.cmd = '0;
        req_if.key = '0;
        req_if.value = '0;
        req_if.first_hash = '0;
        req_if.second_hash = '0;
        rsp_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #25ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/bcht_pkg.sv
src/bcht_intf.sv
src/bcht_ram.sv
src/bcht_ctrl.sv
src/bcht_dp.sv
src/bucketized_cuckoo_hash_table.sv
tb/tb_bucketized_cuckoo_hash_table.sv
